@@ sv/tdx_pkg.sv @@
// Package for the triangular dither block: register index codes and
// noise generator constants. No dependencies.
`default_nettype none

package tdx_pkg;

   // Configuration register index
   localparam int CSR_INDEX_BITS = 2;
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DITHER_STRENGTH = 2'd0,
      CSR_LIMIT_LO        = 2'd1,
      CSR_LIMIT_HI        = 2'd2
   } csr_index_type;

   // Dither strength register
   localparam int STRENGTH_BITS = 8;
   typedef logic [STRENGTH_BITS-1:0] strength_type;

   // xorshift32 generator
   localparam int GEN_BITS = 32;
   typedef logic [GEN_BITS-1:0] gen_type;
   localparam gen_type GEN_SEED = 32'd1835364215;
   localparam int SHIFT_A = 13;
   localparam int SHIFT_B = 17;
   localparam int SHIFT_C = 5;

   // Sum of two centered draws: range [-2^32+2, 2^32-2]
   localparam int NOISE_BITS = GEN_BITS + 2;
   typedef logic signed [NOISE_BITS-1:0] noise_type;

endpackage

`default_nettype wire

@@ sv/tdx_req_if.sv @@
// Input channel of the triangular dither block: valid/ready plus one sample
// and its last flag. No dependencies.
`default_nettype none

interface tdx_req_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] in_sample;
   logic                          in_last;

   modport source (output valid, output in_sample, output in_last, input ready);
   modport sink   (input valid, input in_sample, input in_last, output ready);
endinterface

`default_nettype wire

@@ sv/tdx_rsp_if.sv @@
// Result channel of the triangular dither block: valid/ready plus one
// dithered sample and its last flag. No dependencies.
`default_nettype none

interface tdx_rsp_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_sample;
   logic                          out_last;

   modport source (output valid, output out_sample, output out_last, input ready);
   modport sink   (input valid, input out_sample, input out_last, output ready);
endinterface

`default_nettype wire

@@ sv/tdx_noise.sv @@
// Triangular noise source: xorshift32 state, advanced two steps per noise value.
// Depends on tdx_pkg.
`default_nettype none

module tdx_noise (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   output tdx_pkg::noise_type noise
);
   import tdx_pkg::*;

   function automatic gen_type xorshift(input gen_type x);
      gen_type t;
      t = x ^ (x << SHIFT_A);
      t = t ^ (t >> SHIFT_B);
      t = t ^ (t << SHIFT_C);
      return t;
   endfunction

   gen_type gen_ff;
   gen_type draw1;
   gen_type draw2;

   // two successive draws from the current state
   always_comb begin
      draw1 = xorshift(gen_ff);
      draw2 = xorshift(draw1);
   end

   // sum of centered draws: r1 + r2 - 2^32
   assign noise = NOISE_BITS'({2'b00, draw1}) + NOISE_BITS'({2'b00, draw2})
                - NOISE_BITS'({2'b01, {GEN_BITS{1'b0}}});

   // generator state
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= GEN_SEED;
      end else if (advance) begin
         gen_ff <= draw2;
      end
   end

endmodule

`default_nettype wire

@@ sv/triangular_dither_xorshift.sv @@
// Top level of the triangular dither block: input register, scale/round/
// clamp logic and result register. Depends on tdx_pkg, tdx_req_if,
// tdx_rsp_if and tdx_noise.
//
// Adds triangular-PDF dither from an xorshift32 source to each signed sample
// and clamps the result between the low and high limit registers; the last
// flag rides along. Every sample in arrival order takes the next two
// generator draws, so interleaved channels share one noise stream. One
// transaction is taken per cycle while results are taken; each passes
// through the input register and then the result register, with the
// strength multiply between them, and waits in the input register while
// the result register still holds a result not yet taken. The result
// register lets a new transaction enter while a finished result is still
// waiting. Configuration writes are taken at any time but should only be
// made while the block is idle; a write to an unused index is ignored.
`default_nettype none

module triangular_dither_xorshift #(
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   tdx_req_if.sink                            req_ch,
   tdx_rsp_if.source                          rsp_ch,
   input  wire logic                          csr_we,
   input  wire tdx_pkg::csr_index_type        csr_index,
   input  wire logic [SAMPLE_BITS-1:0]        csr_wdata
);
   import tdx_pkg::*;

   localparam int FACTOR_BITS = STRENGTH_BITS + 2;          // signed strength + 1
   localparam int PROD_BITS   = NOISE_BITS + FACTOR_BITS;
   localparam int DITH_BITS   = PROD_BITS - GEN_BITS;       // after >>> 32
   localparam int V_BITS      = SAMPLE_BITS + 5;            // above DITH_BITS

   // configuration registers
   strength_type                  strength_ff;
   logic signed [SAMPLE_BITS-1:0] lim_lo_ff;
   logic signed [SAMPLE_BITS-1:0] lim_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strength_ff <= '0;
         lim_lo_ff   <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         lim_hi_ff   <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else if (csr_we) begin
         case (csr_index)
            CSR_DITHER_STRENGTH: strength_ff <= csr_wdata[STRENGTH_BITS-1:0];
            CSR_LIMIT_LO:        lim_lo_ff   <= csr_wdata;
            CSR_LIMIT_HI:        lim_hi_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic s2_load;
   logic req_take;

   assign s2_load      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s2_load;
   assign req_take     = req_ch.valid && req_ch.ready;

   // noise source advances once per accepted transaction
   noise_type noise;

   tdx_noise u_noise (
      .clock   (clock),
      .reset   (reset),
      .advance (req_take),
      .noise   (noise)
   );

   // input register
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic                          last_ff;
   noise_type                     noise_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
      if (req_take) begin
         sample_ff <= req_ch.in_sample;
         last_ff   <= req_ch.in_last;
         noise_ff  <= noise;
      end
   end

   // scale, round, add to sample, clamp
   logic signed [FACTOR_BITS-1:0] factor;
   logic signed [PROD_BITS-1:0]   scaled;
   logic signed [PROD_BITS-1:0]   rounded;
   logic signed [DITH_BITS-1:0]   dith;
   logic signed [V_BITS-1:0]      v_sum;
   logic signed [V_BITS-1:0]      v_lim;
   logic signed [V_BITS-1:0]      lo_ext;
   logic signed [V_BITS-1:0]      hi_ext;
   logic signed [SAMPLE_BITS-1:0] result_in;

   always_comb begin
      factor  = FACTOR_BITS'({1'b0, strength_ff}) + FACTOR_BITS'(1);
      scaled  = PROD_BITS'(noise_ff) * PROD_BITS'(factor);
      rounded = scaled + PROD_BITS'({1'b1, {(GEN_BITS-1){1'b0}}});
      dith    = rounded[PROD_BITS-1:GEN_BITS];
      v_sum   = V_BITS'(sample_ff) + V_BITS'(dith);
      lo_ext  = V_BITS'(lim_lo_ff);
      hi_ext  = V_BITS'(lim_hi_ff);
      // high limit first, then low limit wins when limits are inverted
      v_lim   = v_sum;
      if (v_lim > hi_ext) begin
         v_lim = hi_ext;
      end
      if (v_lim < lo_ext) begin
         v_lim = lo_ext;
      end
      result_in = v_lim[SAMPLE_BITS-1:0];
   end

   // result register
   logic signed [SAMPLE_BITS-1:0] out_sample_ff;
   logic                          out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ch.ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (s2_load) begin
         out_sample_ff <= result_in;
         out_last_ff   <= last_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_sample = out_sample_ff;
   assign rsp_ch.out_last   = out_last_ff;

endmodule

`default_nettype wire

@@ test/triangular_dither_xorshift_tb.sv @@
// Testbench for triangular_dither_xorshift: drives samples through the input
// channel and checks every dithered result against an in-bench noise model.
// Depends on tdx_pkg, tdx_req_if, tdx_rsp_if and the block itself.
`timescale 1ns / 100ps

module triangular_dither_xorshift_tb;
   import tdx_pkg::*;

   localparam int SAMPLE_BITS = 24;
   localparam int ROUNDS = 4;             // register settings per idling phase
   localparam int ROUND_ITEMS = 92;       // transactions per register setting
   localparam int DRAIN_CYCLES = 6;       // block latency plus margin
   localparam int STALL_LIMIT = 4000;     // cycles without any transaction
   localparam longint HALF_SPAN = longint'(1) << 31;
   localparam longint FULL_SPAN = longint'(1) << 32;
   localparam longint LEVEL_MIN = -(longint'(1) << (SAMPLE_BITS - 1));
   localparam longint LEVEL_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
   } dithered_item_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   csr_index_type          csr_index;
   logic [SAMPLE_BITS-1:0] csr_wdata;

   tdx_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   tdx_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_bus ();

   triangular_dither_xorshift #(.SAMPLE_BITS(SAMPLE_BITS)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Noise model state and register copies, at their reset values
   gen_type      noise_state = GEN_SEED;
   strength_type strength_q = '0;
   longint       lim_lo_q = LEVEL_MIN;
   longint       lim_hi_q = LEVEL_MAX;

   dithered_item_type expected_dither[$];
   int error_count = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 20;
   int recv_idle_pct = 87;

   // Clock
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // One xorshift32 step
   function automatic gen_type xorshift_next(input gen_type x);
      x ^= x << SHIFT_A;
      x ^= x >> SHIFT_B;
      x ^= x << SHIFT_C;
      return x;
   endfunction

   // Dither one sample: two draws, triangular noise, scale, round, floor, clamp
   function automatic logic signed [SAMPLE_BITS-1:0] dither_level(
      input logic signed [SAMPLE_BITS-1:0] sample);
      longint draw_a;
      longint draw_b;
      longint noise;
      longint level;
      noise_state = xorshift_next(noise_state);
      draw_a = {32'd0, noise_state};
      noise_state = xorshift_next(noise_state);
      draw_b = {32'd0, noise_state};
      noise = (draw_a - HALF_SPAN) + (draw_b - HALF_SPAN);
      noise = noise * (longint'(strength_q) + 1) + HALF_SPAN;
      level = (longint'(sample) * FULL_SPAN + noise) >>> 32;
      // high limit first, then low limit wins when the two are inverted
      if (level > lim_hi_q) level = lim_hi_q;
      if (level < lim_lo_q) level = lim_lo_q;
      return level[SAMPLE_BITS-1:0];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      error_count++;
   endtask

   // Register write; the model copy follows the same field widths
   task automatic write_csr(input csr_index_type index, input logic [SAMPLE_BITS-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         CSR_DITHER_STRENGTH: strength_q = data[STRENGTH_BITS-1:0];
         CSR_LIMIT_LO:        lim_lo_q = longint'($signed(data));
         CSR_LIMIT_HI:        lim_hi_q = longint'($signed(data));
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Send one transaction; entered and left at a falling edge
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] sample, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.in_sample <= sample;
      req_bus.in_last <= last;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Stop sending and let every outstanding result drain
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_dither.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Receiver back-pressure
   always @(negedge clock) rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);

   // Predict on input transactions, check result transactions, watch for stalls
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (req_bus.valid && req_bus.ready) begin
            expected_dither.push_back('{dither_level(req_bus.in_sample), req_bus.in_last});
            quiet_cycles = 0;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            quiet_cycles = 0;
            if (expected_dither.size() == 0) begin
               report_mismatch($sformatf("unexpected result sample %0d last %0b",
                                         rsp_bus.out_sample, rsp_bus.out_last));
            end else begin
               if (rsp_bus.out_sample !== expected_dither[0].sample)
                  report_mismatch($sformatf("out_sample %0d, expected %0d",
                                            rsp_bus.out_sample, expected_dither[0].sample));
               if (rsp_bus.out_last !== expected_dither[0].last)
                  report_mismatch($sformatf("out_last %0b, expected %0b",
                                            rsp_bus.out_last, expected_dither[0].last));
               void'(expected_dither.pop_front());
            end
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("triangular_dither_xorshift regression: fail");
            $finish;
         end
      end
   end

   // Reset register values, zero strength: sample extremes shift by at most one step, clamped at the full range
   task automatic test_reset_defaults();
      send_sample(LEVEL_MAX[SAMPLE_BITS-1:0], 1'b0);
      send_sample(LEVEL_MIN[SAMPLE_BITS-1:0], 1'b1);
      send_sample('0, 1'b0);
      send_sample('1, 1'b1);
      send_sample(24'sd1, 1'b0);
      send_sample(SAMPLE_BITS'(LEVEL_MAX - 1), 1'b1);
      send_sample(SAMPLE_BITS'(LEVEL_MIN + 1), 1'b0);
      wait_idle();
   endtask

   // Full strength, written with junk above the register width
   task automatic test_strength_extremes();
      write_csr(CSR_DITHER_STRENGTH, 24'hABCDFF);
      send_sample(LEVEL_MAX[SAMPLE_BITS-1:0], 1'b0);
      send_sample(LEVEL_MIN[SAMPLE_BITS-1:0], 1'b1);
      send_sample('0, 1'b0);
      wait_idle();
      // only the upper bits set: strength is taken as zero
      write_csr(CSR_DITHER_STRENGTH, 24'h123400);
      send_sample(24'sd5, 1'b1);
      wait_idle();
   endtask

   // Narrow window around zero, then a single allowed value
   task automatic test_clamp_window();
      write_csr(CSR_DITHER_STRENGTH, 24'd255);
      write_csr(CSR_LIMIT_LO, -24'sd100);
      write_csr(CSR_LIMIT_HI, 24'sd100);
      send_sample(LEVEL_MAX[SAMPLE_BITS-1:0], 1'b0);
      send_sample(LEVEL_MIN[SAMPLE_BITS-1:0], 1'b1);
      send_sample(24'sd100, 1'b0);
      send_sample(-24'sd100, 1'b1);
      wait_idle();
      write_csr(CSR_LIMIT_LO, 24'sd7);
      write_csr(CSR_LIMIT_HI, 24'sd7);
      send_sample(LEVEL_MIN[SAMPLE_BITS-1:0], 1'b0);
      send_sample(LEVEL_MAX[SAMPLE_BITS-1:0], 1'b1);
      wait_idle();
   endtask

   // Low limit above high limit: every result lands on the low limit
   task automatic test_inverted_limits();
      write_csr(CSR_LIMIT_LO, 24'sd50);
      write_csr(CSR_LIMIT_HI, -24'sd50);
      send_sample('0, 1'b0);
      send_sample(24'sd1000, 1'b1);
      send_sample(-24'sd1000, 1'b0);
      send_sample(24'sd50, 1'b1);
      wait_idle();
   endtask

   // Random samples over several register settings, half of them near a limit
   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int round = 0; round < ROUNDS; round++) begin
         logic [31:0] word_a;
         logic [31:0] word_b;
         logic signed [SAMPLE_BITS-1:0] lim_a;
         logic signed [SAMPLE_BITS-1:0] lim_b;
         word_a = $urandom;
         word_b = $urandom;
         lim_a = word_a[SAMPLE_BITS-1:0];
         lim_b = word_b[SAMPLE_BITS-1:0];
         case (round)
            0: begin
               write_csr(CSR_DITHER_STRENGTH, '0);
               write_csr(CSR_LIMIT_LO, LEVEL_MIN[SAMPLE_BITS-1:0]);
               write_csr(CSR_LIMIT_HI, LEVEL_MAX[SAMPLE_BITS-1:0]);
            end
            1: begin
               // full strength, ordered random window
               write_csr(CSR_DITHER_STRENGTH, {word_a[15:0], 8'hFF});
               write_csr(CSR_LIMIT_LO, (lim_a < lim_b) ? lim_a : lim_b);
               write_csr(CSR_LIMIT_HI, (lim_a < lim_b) ? lim_b : lim_a);
            end
            2: begin
               // random strength, inverted window
               write_csr(CSR_DITHER_STRENGTH, word_b[SAMPLE_BITS-1:0]);
               write_csr(CSR_LIMIT_LO, (lim_a < lim_b) ? lim_b : lim_a);
               write_csr(CSR_LIMIT_HI, (lim_a < lim_b) ? lim_a : lim_b);
            end
            default: begin
               // limits just inside the sample range
               write_csr(CSR_DITHER_STRENGTH, word_a[SAMPLE_BITS-1:0]);
               write_csr(CSR_LIMIT_LO,
                         SAMPLE_BITS'(LEVEL_MIN + longint'($urandom_range(300))));
               write_csr(CSR_LIMIT_HI,
                         SAMPLE_BITS'(LEVEL_MAX - longint'($urandom_range(300))));
            end
         endcase
         for (int n = 0; n < ROUND_ITEMS; n++) begin
            logic [31:0] word;
            longint near_level;
            word = $urandom;
            case ($urandom_range(3))
               0: near_level = lim_lo_q + longint'($urandom_range(600)) - 300;
               1: near_level = lim_hi_q + longint'($urandom_range(600)) - 300;
               default: near_level = longint'(word);
            endcase
            send_sample(near_level[SAMPLE_BITS-1:0], word[31]);
         end
         wait_idle();
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_DITHER_STRENGTH;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.in_sample = '0;
      req_bus.in_last = 1'b0;
      rsp_bus.ready = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_strength_extremes();
      test_clamp_window();
      test_inverted_limits();
      test_random_traffic(20, 87);
      test_random_traffic(87, 20);
      test_random_traffic(0, 0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("triangular_dither_xorshift regression: pass");
      else
         $display("triangular_dither_xorshift regression: fail");
      $finish;
   end

endmodule
